>>> sv/uart_autobaud_pulse_detector_assert.svh
// ---------------------------------------------------------------------------
// uart_autobaud_pulse_detector assertion macros
// Clocked, reset-gated assertion wrappers used by the checker file.
// ---------------------------------------------------------------------------
`ifndef UART_AUTOBAUD_PULSE_DETECTOR_ASSERT_SVH
`define UART_AUTOBAUD_PULSE_DETECTOR_ASSERT_SVH

// Property checked on every rising edge of i_clk, ignored while in reset.
`define UABPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked on every rising edge of i_clk, reset included.
`define UABPD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> sv/uabpd_pkg.sv
// ---------------------------------------------------------------------------
// uabpd_pkg
// Types, register map and rate table of the auto-baud pulse detector.
// ---------------------------------------------------------------------------
package uabpd_pkg;

    localparam int unsigned RATE_ENTRIES = 5;

    localparam logic [15:0] NO_PULSE       = 16'hFFFF;
    localparam logic [7:0]  VOTES_MAX      = 8'hFF;
    localparam logic [7:0]  RST_VOTE_THR   = 8'd7;
    localparam logic [15:0] RST_NOISE_FLR  = 16'd10;
    localparam logic [7:0]  RST_DIVIDER    = 8'd215;
    localparam logic [15:0] RST_LOW_LIMIT  = 16'd1009;

    // Register index, taken from paddr[2]
    localparam logic REG_VOTE_THR  = 1'b0;
    localparam logic REG_NOISE_FLR = 1'b1;

    typedef enum logic [1:0] {
        OP_RISE  = 2'd0,
        OP_FALL  = 2'd1,
        OP_BOTH  = 2'd2,
        OP_ERROR = 2'd3
    } t_opcode;

    typedef struct packed {
        logic [7:0]  vote_threshold;
        logic [15:0] noise_floor;
    } t_cfg;

    typedef struct packed {
        logic [15:0] narrowest_pulse;
        logic [7:0]  vote_count;
        logic [7:0]  baud_divider;
        logic        rate_changed;
    } t_result;

    localparam logic [7:0] RATE_DIV [RATE_ENTRIES] = '{
        8'd215, 8'd107, 8'd53, 8'd35, 8'd17
    };
    localparam logic [15:0] RATE_LOW [RATE_ENTRIES] = '{
        16'd1009, 16'd504, 16'd252, 16'd168, 16'd83
    };
    localparam logic [15:0] RATE_HIGH [RATE_ENTRIES] = '{
        16'd1074, 16'd537, 16'd268, 16'd179, 16'd90
    };

    // Saturating 8-bit add of a small vote amount
    function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [2:0] b);
        logic [8:0] sum;
        sum = {1'b0, a} + {6'd0, b};
        return sum[8] ? VOTES_MAX : sum[7:0];
    endfunction

endpackage

>>> sv/uart_autobaud_pulse_detector.sv
// An item passes through an input register, then a result register; it moves on
// when the result slot is empty or being drained, so a stalled output holds it there.
// Throughput: one item per cycle while the output is not stalled; the state update
// is one subtract, a few compares and a five-entry parallel table match in between.
// Reset: synchronous, active low; state returns to divider 215, low limit 1009,
// no pulse seen, zero votes; threshold 7 and noise floor 10.
// ---------------------------------------------------------------------------
// uart_autobaud_pulse_detector
// Auto-baud detector: edge timestamps and error reports in, divider out.
// ---------------------------------------------------------------------------
module uart_autobaud_pulse_detector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Item input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [31:0] timestamp, [32] framing_error,
                                        // [33] noise_error, [39:34] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    // Result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [0] rate_changed, [8:1] baud_divider,
                                        // [16:9] vote_count, [32:17] narrowest_pulse,
                                        // [39:33] zero
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import uabpd_pkg::*;

    t_cfg        cfg;
    t_result     core_result;

    // Input register
    logic        r_in_valid;
    logic [1:0]  r_in_opcode;
    logic [31:0] r_in_timestamp;
    logic        r_in_framing;
    logic        r_in_noise;

    // Result register
    logic        r_out_valid;
    t_result     r_out;

    logic        advance;
    logic        in_take;

    // Item moves from input register to result register when the result
    // slot is empty or being drained this cycle; state updates on the same edge.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    uabpd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    uabpd_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (advance),
        .i_cfg           (cfg),
        .i_opcode        (r_in_opcode),
        .i_timestamp     (r_in_timestamp),
        .i_framing_error (r_in_framing),
        .i_noise_error   (r_in_noise),
        .o_result        (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_opcode    <= s_axis_tuser;
            r_in_timestamp <= s_axis_tdata[31:0];
            r_in_framing   <= s_axis_tdata[32];
            r_in_noise     <= s_axis_tdata[33];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.narrowest_pulse, r_out.vote_count,
                            r_out.baud_divider, r_out.rate_changed};

endmodule

>>> sv/uabpd_cfg.sv
// ---------------------------------------------------------------------------
// uabpd_cfg
// APB register file: vote threshold and noise floor.
// ---------------------------------------------------------------------------
module uabpd_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output uabpd_pkg::t_cfg    o_cfg
);
    import uabpd_pkg::*;

    t_cfg r_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vote_threshold <= RST_VOTE_THR;
            r_cfg.noise_floor    <= RST_NOISE_FLR;
        end else if (wr_en) begin
            case (paddr[2])
                REG_VOTE_THR:  r_cfg.vote_threshold <= pwdata[7:0];
                REG_NOISE_FLR: r_cfg.noise_floor    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_VOTE_THR:  prdata = {24'd0, r_cfg.vote_threshold};
            REG_NOISE_FLR: prdata = {16'd0, r_cfg.noise_floor};
            default:       prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> sv/uabpd_core.sv
// ---------------------------------------------------------------------------
// uabpd_core
// Detector state and its combinational update for one item.
// ---------------------------------------------------------------------------
module uabpd_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  uabpd_pkg::t_cfg     i_cfg,
    input  logic [1:0]          i_opcode,
    input  logic [31:0]         i_timestamp,
    input  logic                i_framing_error,
    input  logic                i_noise_error,
    output uabpd_pkg::t_result  o_result
);
    import uabpd_pkg::*;

    logic [31:0] r_last_edge, n_last_edge;
    logic [15:0] r_min_pulse, n_min_pulse;
    logic [7:0]  r_votes,     n_votes;
    logic [7:0]  r_divider,   n_divider;
    logic [15:0] r_low_limit, n_low_limit;
    logic        n_changed;

    always_comb begin
        logic [31:0] width;
        logic        is_edge;
        logic        kept;
        logic [7:0]  votes_upd;
        logic [15:0] min_upd;
        logic        detect;
        logic        found;
        logic [7:0]  sel_div;
        logic [15:0] sel_low;

        width     = i_timestamp - r_last_edge;
        is_edge   = (t_opcode'(i_opcode) == OP_RISE) || (t_opcode'(i_opcode) == OP_FALL);
        kept      = is_edge && (width >= {16'd0, i_cfg.noise_floor});
        votes_upd = r_votes;
        min_upd   = r_min_pulse;

        n_last_edge = is_edge ? i_timestamp : r_last_edge;

        case (t_opcode'(i_opcode))
            OP_RISE, OP_FALL: begin
                if (kept && width < {16'd0, r_low_limit})
                    votes_upd = sat_add(r_votes, 3'd4);
                if (kept && width < {16'd0, r_min_pulse})
                    min_upd = width[15:0];
            end
            OP_ERROR: begin
                votes_upd = sat_add(r_votes,
                                    {1'b0, i_framing_error, i_noise_error});
            end
            default: ;
        endcase

        // Rate lookup on the narrowest pulse, first matching entry wins
        found   = 1'b0;
        sel_div = r_divider;
        sel_low = r_low_limit;
        for (int k = RATE_ENTRIES - 1; k >= 0; k--) begin
            if (min_upd >= RATE_LOW[k] && min_upd <= RATE_HIGH[k]) begin
                found   = 1'b1;
                sel_div = RATE_DIV[k];
                sel_low = RATE_LOW[k];
            end
        end

        detect      = (votes_upd > i_cfg.vote_threshold) && (min_upd != NO_PULSE);
        n_changed   = detect && found && (sel_div != r_divider);
        n_divider   = n_changed ? sel_div : r_divider;
        n_low_limit = n_changed ? sel_low : r_low_limit;
        n_votes     = detect ? 8'd0 : votes_upd;
        n_min_pulse = detect ? NO_PULSE : min_upd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_edge <= 32'd0;
            r_min_pulse <= NO_PULSE;
            r_votes     <= 8'd0;
            r_divider   <= RST_DIVIDER;
            r_low_limit <= RST_LOW_LIMIT;
        end else if (i_advance) begin
            r_last_edge <= n_last_edge;
            r_min_pulse <= n_min_pulse;
            r_votes     <= n_votes;
            r_divider   <= n_divider;
            r_low_limit <= n_low_limit;
        end
    end

    assign o_result.rate_changed    = n_changed;
    assign o_result.baud_divider    = n_divider;
    assign o_result.vote_count      = n_votes;
    assign o_result.narrowest_pulse = n_min_pulse;

endmodule

>>> sv/uabpd_checker.sv
// ---------------------------------------------------------------------------
// uabpd_checker
// Port-level checks of the auto-baud pulse detector, bound to the top level.
// ---------------------------------------------------------------------------
`include "uart_autobaud_pulse_detector_assert.svh"

module uabpd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        pready
);

    // A stalled result keeps its data
    `UABPD_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // Adopting a new divider clears votes and the narrowest pulse
    `UABPD_ASSERT(a_change_clears, m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[16:9] == 8'd0 && m_axis_tdata[32:17] == 16'hFFFF, "rate change without clearing")

    // The divider is always one of the rate table entries
    `UABPD_ASSERT(a_div_legal, m_axis_tvalid |-> m_axis_tdata[8:1] == 8'd215 || m_axis_tdata[8:1] == 8'd107 || m_axis_tdata[8:1] == 8'd53 || m_axis_tdata[8:1] == 8'd35 || m_axis_tdata[8:1] == 8'd17, "divider outside rate table")

    // No result, and pready high, right after a reset cycle
    `UABPD_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> !m_axis_tvalid && pready, "result valid after reset")

endmodule

bind uart_autobaud_pulse_detector uabpd_checker u_uabpd_checker (.*);
